// ===== rtl/core/smrs_pkg.sv =====
// Package for the SPI motor register slave: command codes, state encoding
// and the packed result beat layout.
// No dependencies; used by rtl/core/spi_motor_register_slave.sv.
package smrs_pkg;

  // Default number of motors kept by the slave (three or four).
  localparam int unsigned MOTOR_COUNT_DEFAULT = 4;

  // Byte that opens command mode, and the value loaded into the transmit
  // shifter after every completed byte that does not load a read data byte.
  localparam logic [7:0] SYNC_BYTE = 8'h80;

  // Command byte that leaves command mode.
  localparam logic [7:0] CMD_EXIT = 8'h00;

  // Upper nibble of command bytes.
  localparam logic [3:0] CMD_WRITE = 4'h1;
  localparam logic [3:0] CMD_READ  = 4'h2;

  // Register groups, taken from bits [3:2] of the register code.
  localparam logic [1:0] GRP_TARGET   = 2'd0;
  localparam logic [1:0] GRP_DIVIDER  = 2'd1;
  localparam logic [1:0] GRP_POSITION = 2'd2;
  localparam logic [1:0] GRP_TGT_POS  = 2'd3;

  // Configuration register index.
  localparam logic REG_FOURTH_ENABLE = 1'b0;

  // Reset value of the transmit shifter.
  localparam logic [7:0] TX_RESET = 8'hFF;

  typedef enum logic [3:0] {
    CS_IDLE = 4'd0,
    CS_CMD  = 4'd1,
    CS_WR0  = 4'd4,
    CS_WR1  = 4'd5,
    CS_WR2  = 4'd6,
    CS_WR3  = 4'd7,
    CS_RD0  = 4'd8,
    CS_RD1  = 4'd9,
    CS_RD2  = 4'd10,
    CS_RD3  = 4'd11
  } cmd_state_t;

  // Result beat; the last member sits in the lowest bit.
  typedef struct packed {
    logic [31:0] write_value;
    logic        write_divider;
    logic        write_position;
    logic        write_target;
    logic [1:0]  write_motor;
    logic        write_valid;
    logic        data_out_enable;
    logic        data_out;
  } result_t;

endpackage

// ===== rtl/core/spi_motor_register_slave.sv =====
// SPI motor register slave: pin-sample stream in, pin level and register
// write reports out, with an APB-style port for the fourth-motor enable.
// Depends on rtl/core/smrs_pkg.sv.
//
// The result of an accepted sample beat is registered in the output register.
// Throughput: one sample beat per cycle while the result stream is not
// stalled, set by the single output register, which is refilled in the
// same cycle in which its beat is taken.
// Reset (rst, synchronous, active high): command machine idle, shifters and
// counters cleared, transmit shifter loaded with all ones, motor words zero,
// fourth motor disabled, output register empty.
module spi_motor_register_slave #(
  parameter int unsigned MOTOR_COUNT = smrs_pkg::MOTOR_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Sample stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] chip_select, [1] serial_clock, [2] data_in
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [0] data_out, [1] data_out_enable,
                                 // [2] write_valid, [4:3] write_motor,
                                 // [5] write_target, [6] write_position,
                                 // [7] write_divider, [39:8] write_value
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned MIDX_W = $clog2(MOTOR_COUNT);

  // ---------------------------------------------------------------------
  // Configuration register. Only one register exists, at byte address 0;
  // address bit 2 selects the register index.
  // ---------------------------------------------------------------------
  logic fourth_motor_enable;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == smrs_pkg::REG_FOURTH_ENABLE);
  assign prdata    = (paddr[2] == smrs_pkg::REG_FOURTH_ENABLE) ?
                     {31'd0, fourth_motor_enable} : 32'd0;

  // ---------------------------------------------------------------------
  // Slave state.
  // ---------------------------------------------------------------------
  logic                  last_clock, last_clock_next;
  logic [7:0]            rx_shift, rx_shift_next;
  logic [2:0]            bit_count, bit_count_next;
  logic [7:0]            tx_shift, tx_shift_next;
  logic                  out_pin, out_pin_next;
  smrs_pkg::cmd_state_t  cmd_state, cmd_state_next;
  logic [3:0]            register_select, register_select_next;
  logic [31:0]           value_buffer, value_buffer_next;

  // Target and position words are read back over SPI and are kept here.
  // Divider words are never read back; their writes are reported on the
  // result stream.
  logic [31:0] motor_targets   [MOTOR_COUNT];
  logic [31:0] motor_positions [MOTOR_COUNT];

  smrs_pkg::result_t result, result_next;

  logic accept;
  logic sample_select, sample_clock, sample_data;
  logic byte_done;
  logic commit;

  assign s_tready      = !m_tvalid || m_tready;
  assign accept        = s_tvalid && s_tready;
  assign sample_select = s_tdata[0];
  assign sample_clock  = s_tdata[1];
  assign sample_data   = s_tdata[2];
  assign m_tdata       = result;

  // A motor index is usable if it is one of the first three, or it is the
  // fourth motor, which exists and has been enabled.
  function automatic logic motor_ok(input logic [1:0] m, input logic enable);
    logic ok;
    if (m != 2'd3) begin
      ok = 1'b1;
    end else begin
      ok = (MOTOR_COUNT >= 4) && enable;
    end
    return ok;
  endfunction

  // ---------------------------------------------------------------------
  // Next state for one sample. The whole step is evaluated here and is
  // applied only when the sample beat is accepted.
  // ---------------------------------------------------------------------
  always_comb begin
    logic       shift;
    logic [7:0] rx_new;
    logic [7:0] tx_work;
    logic [1:0] rd_motor;
    logic [1:0] wr_motor;
    logic [1:0] wr_group;

    last_clock_next      = sample_clock;
    rx_shift_next        = rx_shift;
    bit_count_next       = bit_count;
    tx_shift_next        = tx_shift;
    out_pin_next         = out_pin;
    cmd_state_next       = cmd_state;
    register_select_next = register_select;
    value_buffer_next    = value_buffer;
    commit               = 1'b0;

    shift     = sample_select && sample_clock && !last_clock;
    rx_new    = {rx_shift[6:0], sample_data};
    byte_done = shift && (bit_count == 3'd7);
    tx_work   = tx_shift;
    rd_motor  = rx_new[1:0];
    wr_motor  = register_select[1:0];
    wr_group  = register_select[3:2];

    if (shift) begin
      rx_shift_next  = rx_new;
      bit_count_next = bit_count + 3'd1;
    end

    if (byte_done) begin
      tx_work = smrs_pkg::SYNC_BYTE;
      unique case (cmd_state)
        smrs_pkg::CS_IDLE: begin
          if (rx_new == smrs_pkg::SYNC_BYTE) begin
            cmd_state_next = smrs_pkg::CS_CMD;
          end else begin
            // Slip framing by one bit: the next byte ends after one more bit.
            bit_count_next = 3'd7;
          end
        end
        smrs_pkg::CS_CMD: begin
          if (rx_new == smrs_pkg::CMD_EXIT) begin
            cmd_state_next = smrs_pkg::CS_IDLE;
          end else if (rx_new[7:4] == smrs_pkg::CMD_WRITE) begin
            register_select_next = rx_new[3:0];
            cmd_state_next       = smrs_pkg::CS_WR0;
          end else if (rx_new[7:4] == smrs_pkg::CMD_READ) begin
            cmd_state_next = smrs_pkg::CS_RD0;
            // Unusable motors and unused codes leave the buffer as it was.
            if (motor_ok(rd_motor, fourth_motor_enable)) begin
              if (rx_new[3:2] == smrs_pkg::GRP_TARGET) begin
                value_buffer_next = motor_targets[rd_motor[MIDX_W-1:0]];
              end else if (rx_new[3:2] == smrs_pkg::GRP_POSITION) begin
                value_buffer_next = motor_positions[rd_motor[MIDX_W-1:0]];
              end
            end
          end
        end
        smrs_pkg::CS_WR0: begin
          value_buffer_next = {24'd0, rx_new};
          cmd_state_next    = smrs_pkg::CS_WR1;
        end
        smrs_pkg::CS_WR1: begin
          value_buffer_next = {value_buffer[23:0], rx_new};
          cmd_state_next    = smrs_pkg::CS_WR2;
        end
        smrs_pkg::CS_WR2: begin
          value_buffer_next = {value_buffer[23:0], rx_new};
          cmd_state_next    = smrs_pkg::CS_WR3;
        end
        smrs_pkg::CS_WR3: begin
          value_buffer_next = {value_buffer[23:0], rx_new};
          commit            = motor_ok(wr_motor, fourth_motor_enable);
          cmd_state_next    = smrs_pkg::CS_CMD;
        end
        smrs_pkg::CS_RD0: begin
          tx_work        = value_buffer[31:24];
          cmd_state_next = smrs_pkg::CS_RD1;
        end
        smrs_pkg::CS_RD1: begin
          tx_work        = value_buffer[23:16];
          cmd_state_next = smrs_pkg::CS_RD2;
        end
        smrs_pkg::CS_RD2: begin
          tx_work        = value_buffer[15:8];
          cmd_state_next = smrs_pkg::CS_RD3;
        end
        smrs_pkg::CS_RD3: begin
          tx_work        = value_buffer[7:0];
          cmd_state_next = smrs_pkg::CS_CMD;
        end
        default: begin
          cmd_state_next = smrs_pkg::CS_IDLE;
        end
      endcase
    end

    // The pin takes the top bit after any reload on a completed byte.
    if (shift) begin
      out_pin_next  = tx_work[7];
      tx_shift_next = {tx_work[6:0], 1'b0};
    end

    result_next                 = '0;
    result_next.data_out        = out_pin_next;
    result_next.data_out_enable = sample_select;
    if (commit) begin
      result_next.write_valid    = 1'b1;
      result_next.write_motor    = wr_motor;
      result_next.write_value    = value_buffer_next;
      result_next.write_target   = (wr_group == smrs_pkg::GRP_TARGET) ||
                                   (wr_group == smrs_pkg::GRP_TGT_POS);
      result_next.write_position = (wr_group == smrs_pkg::GRP_POSITION) ||
                                   (wr_group == smrs_pkg::GRP_TGT_POS);
      result_next.write_divider  = (wr_group == smrs_pkg::GRP_DIVIDER);
    end
  end

  // ---------------------------------------------------------------------
  // State, motor words and configuration.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fourth_motor_enable <= 1'b0;
      last_clock          <= 1'b0;
      rx_shift            <= 8'd0;
      bit_count           <= 3'd0;
      tx_shift            <= smrs_pkg::TX_RESET;
      out_pin             <= 1'b0;
      cmd_state           <= smrs_pkg::CS_IDLE;
      register_select     <= 4'd0;
      value_buffer        <= 32'd0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        motor_targets[i]   <= 32'd0;
        motor_positions[i] <= 32'd0;
      end
    end else begin
      if (cfg_write) begin
        fourth_motor_enable <= pwdata[0];
      end
      if (accept) begin
        last_clock      <= last_clock_next;
        rx_shift        <= rx_shift_next;
        bit_count       <= bit_count_next;
        tx_shift        <= tx_shift_next;
        out_pin         <= out_pin_next;
        cmd_state       <= cmd_state_next;
        register_select <= register_select_next;
        value_buffer    <= value_buffer_next;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          if (commit && (register_select[MIDX_W-1:0] == MIDX_W'(i))) begin
            if (result_next.write_target) begin
              motor_targets[i] <= value_buffer_next;
            end
            if (result_next.write_position) begin
              motor_positions[i] <= value_buffer_next;
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: it is refilled whenever a sample beat is accepted,
  // which may be in the same cycle as its previous beat is taken.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------

  // An accepted sample always leaves a result beat waiting.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted sample did not produce a result beat");

  // Without a committed write, all write report fields are zero.
  a_quiet_report: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !result.write_valid) |->
      (result.write_value == 32'd0 && result.write_motor == 2'd0 &&
       !result.write_target && !result.write_position && !result.write_divider))
    else $error("write report fields set without a committed write");

  // A committed write hits the divider alone or target and/or position.
  a_write_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.write_valid) |->
      (result.write_divider != (result.write_target || result.write_position)))
    else $error("committed write has an inconsistent register group");

  // A byte other than the sync byte in idle slips framing by one bit.
  a_frame_slip: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_done && cmd_state == smrs_pkg::CS_IDLE &&
     rx_shift_next != smrs_pkg::SYNC_BYTE) |=> (bit_count == 3'd7))
    else $error("framing did not slip after a non-sync byte in idle");

endmodule
